### rtl/brd_pkg.sv
// Shared types, codes and sizes for the boolean range decoder.
package brd_pkg;

    // Coded-byte queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW = QAW + 1;

    localparam logic [7:0] HALF_PROB    = 8'd128;
    localparam logic [3:0] LIT_MAX      = 4'd8;
    localparam logic [3:0] START_SHIFTS = 4'd8;
    localparam logic [7:0] FULL_RANGE   = 8'd255;

    typedef enum logic [2:0] {
        ACT_START  = 3'd0,
        ACT_PUSH   = 3'd1,
        ACT_BOOL   = 3'd2,
        ACT_LIT    = 3'd3,
        ACT_FINISH = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_DECIDE,
        ST_SHIFT,
        ST_FETCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [3:0] literal_width;
        logic [7:0] probability;
        logic [7:0] coded_byte;
        logic [2:0] action;
    } item_t;

    typedef struct packed {
        logic       queue_full;
        logic       overread;
        logic [7:0] decoded_value;
    } result_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } q_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

### rtl/brd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/brd_queue.sv
// Circular byte queue holding coded bytes ahead of the decoder.
module brd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  brd_pkg::q_cmd_t cmd,
    output brd_pkg::q_stat_t stat,
    output logic [7:0]      rdata
);
    import brd_pkg::*;

    logic [QAW-1:0] head_reg, head_next;
    logic [QCW-1:0] count_reg, count_next;
    logic [QSW-1:0] tail_sum;
    logic [QSW-1:0] tail_wrap;
    logic           do_push;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QUEUE_DEPTH));
    assign do_push    = cmd.push && !stat.full;

    assign tail_sum  = QSW'(head_reg) + QSW'(count_reg);
    assign tail_wrap = (tail_sum >= QSW'(QUEUE_DEPTH)) ? tail_sum - QSW'(QUEUE_DEPTH)
                                                       : tail_sum;

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop) begin
            head_next = (head_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        case ({do_push, cmd.pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    brd_ram #(
        .WIDTH(8),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (do_push),
        .waddr(tail_wrap[QAW-1:0]),
        .wdata(cmd.wdata),
        .raddr(head_reg),
        .rdata(rdata)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCW'(QUEUE_DEPTH))
        else $error("queue count past depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !stat.empty)
        else $error("pop from empty queue");

endmodule

### rtl/brd_core.sv
// Sequencer and shared split/compare/shift unit of the bool decoder.
module brd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  brd_pkg::item_t   item,
    input  logic             out_free,
    output logic             idle,
    output logic             done,
    output brd_pkg::result_t result,
    output brd_pkg::q_cmd_t  q_cmd,
    input  brd_pkg::q_stat_t q_stat,
    input  logic [7:0]       q_rdata
);
    import brd_pkg::*;

    state_t      state_reg, state_next;
    logic [7:0]  range_reg, range_next;
    logic [15:0] window_reg, window_next;
    logic [3:0]  wbits_reg, wbits_next;
    logic        over_reg, over_next;
    logic [7:0]  prob_reg, prob_next;
    logic [7:0]  split_reg, split_next;
    logic [3:0]  lit_cnt_reg, lit_cnt_next;
    logic [3:0]  shift_cnt_reg, shift_cnt_next;
    logic        start_mode_reg, start_mode_next;
    logic [7:0]  value_reg, value_next;
    logic        full_reg, full_next;

    logic [15:0] prod;
    logic        bit_one;
    logic        need_shift;
    logic        need_fetch;
    logic [3:0]  lit_width;

    assign prod       = {8'd0, range_reg - 8'd1} * {8'd0, prob_reg};
    assign bit_one    = (window_reg[15:8] >= split_reg);
    assign need_shift = start_mode_reg ? (shift_cnt_reg != 4'd0) : !range_reg[7];
    assign need_fetch = (wbits_reg == 4'd0) && !q_stat.empty;
    assign lit_width  = (item.literal_width > LIT_MAX) ? LIT_MAX : item.literal_width;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    case (item.action)
                        ACT_START: state_next = ST_SHIFT;
                        ACT_BOOL:  state_next = ST_SPLIT;
                        ACT_LIT:   state_next = (lit_width == 4'd0) ? ST_DONE : ST_SPLIT;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_SPLIT:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (need_shift) begin
                    state_next = need_fetch ? ST_FETCH : ST_SHIFT;
                end else if (!start_mode_reg && lit_cnt_reg != 4'd0) begin
                    state_next = ST_SPLIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FETCH: state_next = ST_SHIFT;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        range_next      = range_reg;
        window_next     = window_reg;
        wbits_next      = wbits_reg;
        over_next       = over_reg;
        prob_next       = prob_reg;
        split_next      = split_reg;
        lit_cnt_next    = lit_cnt_reg;
        shift_cnt_next  = shift_cnt_reg;
        start_mode_next = start_mode_reg;
        value_next      = value_reg;
        full_next       = full_reg;
        q_cmd.push      = 1'b0;
        q_cmd.pop       = 1'b0;
        q_cmd.wdata     = item.coded_byte;
        idle            = (state_reg == ST_IDLE);
        done            = (state_reg == ST_DONE) && out_free;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    value_next = 8'd0;
                    full_next  = 1'b0;
                    case (item.action)
                        ACT_START: begin
                            range_next      = FULL_RANGE;
                            window_next     = 16'd0;
                            wbits_next      = 4'd0;
                            over_next       = 1'b0;
                            shift_cnt_next  = START_SHIFTS;
                            start_mode_next = 1'b1;
                        end
                        ACT_PUSH: begin
                            q_cmd.push = !q_stat.full;
                            full_next  = q_stat.full;
                        end
                        ACT_BOOL: begin
                            prob_next       = item.probability;
                            lit_cnt_next    = 4'd1;
                            start_mode_next = 1'b0;
                        end
                        ACT_LIT: begin
                            prob_next       = HALF_PROB;
                            lit_cnt_next    = lit_width;
                            start_mode_next = 1'b0;
                        end
                        default: begin
                            value_next = 8'd0;
                        end
                    endcase
                end
            end
            ST_SPLIT: begin
                split_next = 8'd1 + prod[15:8];
            end
            ST_DECIDE: begin
                if (bit_one) begin
                    range_next  = range_reg - split_reg;
                    window_next = window_reg - {split_reg, 8'h00};
                end else begin
                    range_next = split_reg;
                end
                value_next   = {value_reg[6:0], bit_one};
                lit_cnt_next = lit_cnt_reg - 4'd1;
            end
            ST_SHIFT: begin
                if (need_shift && !need_fetch) begin
                    if (wbits_reg != 4'd0) begin
                        window_next = {window_reg[14:0], 1'b0};
                        wbits_next  = wbits_reg - 4'd1;
                    end else begin
                        // queue dry: shift in a zero and flag it
                        window_next = {window_reg[14:8], 9'h000};
                        over_next   = 1'b1;
                    end
                    if (start_mode_reg) begin
                        shift_cnt_next = shift_cnt_reg - 4'd1;
                    end else begin
                        range_next = {range_reg[6:0], 1'b0};
                    end
                end
            end
            ST_FETCH: begin
                window_next = {window_reg[14:8], q_rdata, 1'b0};
                wbits_next  = 4'd7;
                q_cmd.pop   = 1'b1;
                if (start_mode_reg) begin
                    shift_cnt_next = shift_cnt_reg - 4'd1;
                end else begin
                    range_next = {range_reg[6:0], 1'b0};
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    assign result.decoded_value = value_reg;
    assign result.overread      = over_reg;
    assign result.queue_full    = full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            range_reg      <= FULL_RANGE;
            window_reg     <= 16'd0;
            wbits_reg      <= 4'd0;
            over_reg       <= 1'b0;
            start_mode_reg <= 1'b0;
            lit_cnt_reg    <= 4'd0;
            shift_cnt_reg  <= 4'd0;
        end else begin
            state_reg      <= state_next;
            range_reg      <= range_next;
            window_reg     <= window_next;
            wbits_reg      <= wbits_next;
            over_reg       <= over_next;
            start_mode_reg <= start_mode_next;
            lit_cnt_reg    <= lit_cnt_next;
            shift_cnt_reg  <= shift_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        prob_reg  <= prob_next;
        split_reg <= split_next;
        value_reg <= value_next;
        full_reg  <= full_next;
    end

    a_range_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> range_reg[7])
        else $error("range not normalized between items");

    a_wbits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wbits_reg <= 4'd8)
        else $error("window bit count out of range");

    a_fetch_has_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> !q_stat.empty)
        else $error("byte fetch with empty queue");

endmodule

### rtl/boolean_range_decoder.sv
// Top level: VP8/VP9 boolean range decoder with a coded-byte queue.
//
//  channel | dir | beat contents (lowest bit first)
//  --------+-----+-----------------------------------------------------------
//  s_      | in  | tuser: action[2:0]
//          |     | tdata: coded_byte[7:0] probability[15:8]
//          |     |        literal_width[19:16], zero pad to 24 bits
//  m_      | out | tdata: decoded_value[7:0] overread[8] queue_full[9], pad to 16
//
// After accept: push, finish, unused and zero-width literal go straight to result load;
// a bool runs split multiply, compare/subtract, renormalizing shifts plus a
// closing check, a fetch step for each byte popped, then the result load.
// A literal repeats split, compare and shifts per bit; start runs its 8 shifts.
// s_tready is high only while the sequencer idles, from the edge that loads m_;
// a result still held in m_ stalls the sequencer in its last cycle.
// Reset (aresetn low, synchronous) empties the queue, sets range to 255 and
// clears the window and overread flag; queue storage itself is not cleared.
module boolean_range_decoder (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // coded_byte, probability, literal_width
    input  logic [2:0]  s_tuser,   // action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // decoded_value, overread, queue_full
);
    import brd_pkg::*;

    item_t   item;
    result_t result;
    q_cmd_t  q_cmd;
    q_stat_t q_stat;
    logic [7:0] q_rdata;

    logic core_idle;
    logic core_done;
    logic start;
    logic out_free;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;

    // unpack the input beat
    assign item.action        = s_tuser;
    assign item.coded_byte    = s_tdata[7:0];
    assign item.probability   = s_tdata[15:8];
    assign item.literal_width = s_tdata[19:16];

    assign s_tready = core_idle;
    assign start    = s_tvalid && s_tready;

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    brd_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (q_cmd),
        .stat   (q_stat),
        .rdata  (q_rdata)
    );

    brd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .item    (item),
        .out_free(out_free),
        .idle    (core_idle),
        .done    (core_done),
        .result  (result),
        .q_cmd   (q_cmd),
        .q_stat  (q_stat),
        .q_rdata (q_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (core_done) begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, result};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
